>>> rtl/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, character codes and ID decode helpers for the NMEA parser.
// ----------------------------------------------------------------------------
`default_nettype none

package nsp_pkg;

   // character codes
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_BANG   = 8'h21;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_P      = 8'h50;

   // result kinds
   localparam logic KIND_CHAR    = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // summary status codes
   localparam logic [1:0] STATUS_PARSED      = 2'd0;
   localparam logic [1:0] STATUS_PROPRIETARY = 2'd1;
   localparam logic [1:0] STATUS_FORMAT_ERR  = 2'd2;

   // talker codes
   localparam logic [2:0] TALKER_UNKNOWN = 3'd0;
   localparam logic [2:0] TALKER_GPS     = 3'd1;
   localparam logic [2:0] TALKER_GALILEO = 3'd2;
   localparam logic [2:0] TALKER_BEIDOU  = 3'd3;
   localparam logic [2:0] TALKER_GLONASS = 3'd4;
   localparam logic [2:0] TALKER_GNSS    = 3'd5;
   localparam logic [2:0] TALKER_QZSS    = 3'd6;

   // sentence codes
   localparam logic [2:0] SENT_UNKNOWN = 3'd0;
   localparam logic [2:0] SENT_GGA     = 3'd1;
   localparam logic [2:0] SENT_GLL     = 3'd2;
   localparam logic [2:0] SENT_GSA     = 3'd3;
   localparam logic [2:0] SENT_GSV     = 3'd4;
   localparam logic [2:0] SENT_RMC     = 3'd5;
   localparam logic [2:0] SENT_VTG     = 3'd6;

   // register map
   localparam logic REG_MAX_LENGTH = 1'b0;
   localparam logic [7:0] MAX_LENGTH_RESET = 8'd82;

   localparam int unsigned CNT_W = 7;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [39:0] id_type;

   // id byte k sits at bits 8k+7:8k; talker in bytes 0..1
   function automatic logic [2:0] decode_talker(input id_type id);
      logic [15:0] t;
      t = {id[15:8], id[7:0]};
      case (t)
         {8'h50, 8'h47}: decode_talker = TALKER_GPS;      // GP
         {8'h41, 8'h47}: decode_talker = TALKER_GALILEO;  // GA
         {8'h42, 8'h47}: decode_talker = TALKER_BEIDOU;   // GB
         {8'h44, 8'h42}: decode_talker = TALKER_BEIDOU;   // BD
         {8'h4C, 8'h47}: decode_talker = TALKER_GLONASS;  // GL
         {8'h4E, 8'h47}: decode_talker = TALKER_GNSS;     // GN
         {8'h51, 8'h47}: decode_talker = TALKER_QZSS;     // GQ
         default:        decode_talker = TALKER_UNKNOWN;
      endcase
   endfunction

   // sentence id in bytes 2..4
   function automatic logic [2:0] decode_sentence(input id_type id);
      logic [23:0] s;
      s = {id[23:16], id[31:24], id[39:32]};
      case (s)
         {8'h47, 8'h47, 8'h41}: decode_sentence = SENT_GGA;
         {8'h47, 8'h4C, 8'h4C}: decode_sentence = SENT_GLL;
         {8'h47, 8'h53, 8'h41}: decode_sentence = SENT_GSA;
         {8'h47, 8'h53, 8'h56}: decode_sentence = SENT_GSV;
         {8'h52, 8'h4D, 8'h43}: decode_sentence = SENT_RMC;
         {8'h56, 8'h54, 8'h47}: decode_sentence = SENT_VTG;
         default:               decode_sentence = SENT_UNKNOWN;
      endcase
   endfunction

   // bit 4 set for a non-hex character
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) begin
         hex_value = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         hex_value = {1'b0, c[3:0] + 4'd9};
      end else begin
         hex_value = 5'h10;
      end
   endfunction

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == CNT_MAX) ? v : v + count_type'(1);
   endfunction

endpackage

`default_nettype wire

>>> rtl/nmea_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// Byte-serial NMEA 0183 parser: field characters and a per-sentence summary.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_data_byte
//  rsp       out        rsp_valid/rsp_stall  kind .. status (one beat per result)
//  csr       in/out     apb, pready tied 1   max_length at byte address 0
//
//  one byte per cycle unless stalled: each beat is decoded by a single layer of
//  logic from the sentence state and lands in the result register on the same edge
//  a byte yields at most one result beat; the result register is the only stage
//  reset is synchronous and clears sentence state and the result valid
//  req_stall is high only while a result sits in the register and rsp_stall is
//  high; a taken result frees the register for the next byte in the same cycle
`default_nettype none

module nmea_sentence_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // byte input
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_data_byte,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic                       rsp_kind,
   output logic [6:0]                 rsp_field_index,
   output logic [6:0]                 rsp_char_position,
   output logic [7:0]                 rsp_char_value,
   output logic [2:0]                 rsp_talker_code,
   output logic [2:0]                 rsp_sentence_code,
   output logic [6:0]                 rsp_field_count,
   output logic                       rsp_checksum_present,
   output logic                       rsp_sentence_valid,
   output logic [1:0]                 rsp_status,
   // configuration
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [2:0]            csr_paddr,
   input  wire logic [31:0]           csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);
   import nsp_pkg::*;

   // configuration register
   logic [7:0] max_length_ff, max_length_in;

   // sentence state
   logic        in_sentence_ff, in_sentence_in;
   logic [7:0]  byte_pos_ff, byte_pos_in;
   id_type      id_chars_ff, id_chars_in;
   logic [7:0]  xor_acc_ff, xor_acc_in;
   logic        star_seen_ff, star_seen_in;
   logic        error_ff, error_in;
   logic        prop_ff, prop_in;
   count_type   field_cnt_ff, field_cnt_in;
   count_type   char_cnt_ff, char_cnt_in;
   logic        pend_valid_ff, pend_valid_in;
   logic [7:0]  pend_byte_ff, pend_byte_in;
   logic [7:0]  rx_csum_ff, rx_csum_in;
   count_type   digit_cnt_ff, digit_cnt_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        kind_ff, kind_in;
   count_type   fidx_ff, fidx_in;
   count_type   cpos_ff, cpos_in;
   logic [7:0]  cval_ff, cval_in;
   logic [2:0]  talker_ff, talker_in;
   logic [2:0]  sent_ff, sent_in;
   count_type   fcount_ff, fcount_in;
   logic        csum_pres_ff, csum_pres_in;
   logic        sent_valid_ff, sent_valid_in;
   logic [1:0]  status_ff, status_in;

   logic       accept;
   logic       emit;
   logic [7:0] b;
   logic [4:0] hex;
   logic       cfg_write;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign b         = req_data_byte;
   assign hex       = hex_value(pend_byte_ff);

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2] == REG_MAX_LENGTH);
   assign csr_prdata = (csr_paddr[2] == REG_MAX_LENGTH) ? {24'd0, max_length_ff} : 32'd0;
   assign max_length_in = cfg_write ? csr_pwdata[7:0] : max_length_ff;

   // ---------------------------------------------------------------- per-byte logic
   always_comb begin
      in_sentence_in = in_sentence_ff;
      byte_pos_in    = byte_pos_ff;
      id_chars_in    = id_chars_ff;
      xor_acc_in     = xor_acc_ff;
      star_seen_in   = star_seen_ff;
      error_in       = error_ff;
      prop_in        = prop_ff;
      field_cnt_in   = field_cnt_ff;
      char_cnt_in    = char_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_byte_in   = pend_byte_ff;
      rx_csum_in     = rx_csum_ff;
      digit_cnt_in   = digit_cnt_ff;

      emit          = 1'b0;
      kind_in       = KIND_CHAR;
      fidx_in       = '0;
      cpos_in       = '0;
      cval_in       = '0;
      talker_in     = TALKER_UNKNOWN;
      sent_in       = SENT_UNKNOWN;
      fcount_in     = '0;
      csum_pres_in  = 1'b0;
      sent_valid_in = 1'b0;
      status_in     = STATUS_PARSED;

      if (accept) begin
         if (b == CHAR_DOLLAR || b == CHAR_BANG) begin
            // start marker: drop whatever was in progress
            in_sentence_in = 1'b1;
            byte_pos_in    = 8'd1;
            id_chars_in    = '0;
            xor_acc_in     = '0;
            star_seen_in   = 1'b0;
            error_in       = 1'b0;
            prop_in        = 1'b0;
            field_cnt_in   = '0;
            char_cnt_in    = '0;
            pend_valid_in  = 1'b0;
            pend_byte_in   = '0;
            rx_csum_in     = '0;
            digit_cnt_in   = '0;
         end else if (in_sentence_ff) begin
            if (byte_pos_ff != 8'hFF) begin
               byte_pos_in = byte_pos_ff + 8'd1;
            end
            if (b == CHAR_LF) begin
               // end of sentence: summary beat, then back to hunting
               emit    = 1'b1;
               kind_in = KIND_SUMMARY;
               if (prop_ff) begin
                  status_in = STATUS_PROPRIETARY;
               end else if (error_ff || !pend_valid_ff || pend_byte_ff != CHAR_CR ||
                            ({1'b0, byte_pos_ff} + 9'd1) > {1'b0, max_length_ff}) begin
                  status_in = STATUS_FORMAT_ERR;
               end else begin
                  talker_in     = decode_talker(id_chars_ff);
                  sent_in       = decode_sentence(id_chars_ff);
                  fcount_in     = sat_inc(field_cnt_ff);
                  csum_pres_in  = star_seen_ff;
                  sent_valid_in = !star_seen_ff ||
                                  (digit_cnt_ff == count_type'(2) && rx_csum_ff == xor_acc_ff);
               end
               in_sentence_in = 1'b0;
               byte_pos_in    = '0;
               id_chars_in    = '0;
               xor_acc_in     = '0;
               star_seen_in   = 1'b0;
               error_in       = 1'b0;
               prop_in        = 1'b0;
               field_cnt_in   = '0;
               char_cnt_in    = '0;
               pend_valid_in  = 1'b0;
               pend_byte_in   = '0;
               rx_csum_in     = '0;
               digit_cnt_in   = '0;
            end else if (byte_pos_ff <= 8'd5) begin
               // talker and sentence id
               case (byte_pos_ff[2:0])
                  3'd1:    id_chars_in[7:0]   = id_chars_ff[7:0]   | b;
                  3'd2:    id_chars_in[15:8]  = id_chars_ff[15:8]  | b;
                  3'd3:    id_chars_in[23:16] = id_chars_ff[23:16] | b;
                  3'd4:    id_chars_in[31:24] = id_chars_ff[31:24] | b;
                  3'd5:    id_chars_in[39:32] = id_chars_ff[39:32] | b;
                  default: id_chars_in        = id_chars_ff;
               endcase
               if (byte_pos_ff == 8'd1 && b == CHAR_P) begin
                  prop_in = 1'b1;
               end
               xor_acc_in = xor_acc_ff ^ b;
            end else if (byte_pos_ff == 8'd6) begin
               if (b != CHAR_COMMA) begin
                  error_in = 1'b1;
               end
               xor_acc_in = xor_acc_ff ^ b;
            end else begin
               // release the held character, one byte late
               if (pend_valid_ff) begin
                  if (!prop_ff) begin
                     emit    = 1'b1;
                     fidx_in = field_cnt_ff;
                     cpos_in = char_cnt_ff;
                     cval_in = pend_byte_ff;
                  end
                  if (star_seen_ff) begin
                     if (hex[4]) begin
                        error_in = 1'b1;
                     end else begin
                        rx_csum_in = {rx_csum_ff[3:0], hex[3:0]};
                     end
                     digit_cnt_in = sat_inc(digit_cnt_ff);
                  end
                  char_cnt_in   = sat_inc(char_cnt_ff);
                  pend_valid_in = 1'b0;
                  pend_byte_in  = '0;
               end
               if (b == CHAR_COMMA || b == CHAR_STAR) begin
                  if (star_seen_ff) begin
                     error_in = 1'b1;
                  end else if (b == CHAR_COMMA) begin
                     xor_acc_in = xor_acc_ff ^ b;
                  end
                  if (b == CHAR_STAR) begin
                     star_seen_in = 1'b1;
                  end
                  field_cnt_in = sat_inc(field_cnt_ff);
                  char_cnt_in  = '0;
               end else begin
                  pend_valid_in = 1'b1;
                  pend_byte_in  = b;
                  if (!star_seen_ff) begin
                     xor_acc_in = xor_acc_ff ^ b;
                  end
               end
            end
         end
      end

      // hold a stalled beat, drop a taken one, load a new one
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff  <= MAX_LENGTH_RESET;
         in_sentence_ff <= 1'b0;
         byte_pos_ff    <= '0;
         id_chars_ff    <= '0;
         xor_acc_ff     <= '0;
         star_seen_ff   <= 1'b0;
         error_ff       <= 1'b0;
         prop_ff        <= 1'b0;
         field_cnt_ff   <= '0;
         char_cnt_ff    <= '0;
         pend_valid_ff  <= 1'b0;
         pend_byte_ff   <= '0;
         rx_csum_ff     <= '0;
         digit_cnt_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_length_ff  <= max_length_in;
         in_sentence_ff <= in_sentence_in;
         byte_pos_ff    <= byte_pos_in;
         id_chars_ff    <= id_chars_in;
         xor_acc_ff     <= xor_acc_in;
         star_seen_ff   <= star_seen_in;
         error_ff       <= error_in;
         prop_ff        <= prop_in;
         field_cnt_ff   <= field_cnt_in;
         char_cnt_ff    <= char_cnt_in;
         pend_valid_ff  <= pend_valid_in;
         pend_byte_ff   <= pend_byte_in;
         rx_csum_ff     <= rx_csum_in;
         digit_cnt_ff   <= digit_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff       <= kind_in;
         fidx_ff       <= fidx_in;
         cpos_ff       <= cpos_in;
         cval_ff       <= cval_in;
         talker_ff     <= talker_in;
         sent_ff       <= sent_in;
         fcount_ff     <= fcount_in;
         csum_pres_ff  <= csum_pres_in;
         sent_valid_ff <= sent_valid_in;
         status_ff     <= status_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_field_index      = fidx_ff;
   assign rsp_char_position    = cpos_ff;
   assign rsp_char_value       = cval_ff;
   assign rsp_talker_code      = talker_ff;
   assign rsp_sentence_code    = sent_ff;
   assign rsp_field_count      = fcount_ff;
   assign rsp_checksum_present = csum_pres_ff;
   assign rsp_sentence_valid   = sent_valid_ff;
   assign rsp_status           = status_ff;

endmodule

`default_nettype wire
